@@ rtl/lbs_pkg.sv @@
package lbs_pkg;

  localparam int MAX_STYLES  = 4;
  localparam int MAX_SIDE    = 32;
  localparam int STORE_DEPTH = 4096;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CALC_W = $clog2(MAX_STYLES * MAX_SIDE * MAX_SIDE) + 1;
  localparam int SIDE_W = $clog2(MAX_SIDE) + 1;
  localparam int STY_W  = $clog2(MAX_STYLES + 1);

  localparam int TEXEL_W = 24;
  localparam int WT_W    = 17;
  localparam int SUM_W   = 24;
  localparam int GAIN_W  = 10;
  localparam int ACC_W   = 37;
  localparam int LANE_AW = 24;
  localparam int LANE_BW = 17;
  localparam int LANE_PW = LANE_AW + LANE_BW;
  localparam int LANES   = 3;

  localparam logic [2:0] CFG_MAP_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_MAP_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_STYLE_COUNT = 3'd2;
  localparam logic [2:0] CFG_GAIN_ZERO   = 3'd3;
  localparam logic [2:0] CFG_GAIN_ONE    = 3'd4;
  localparam logic [2:0] CFG_GAIN_TWO    = 3'd5;
  localparam logic [2:0] CFG_GAIN_THREE  = 3'd6;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef struct packed {
    logic        action;
    logic [11:0] texel_index;
    logic [7:0]  texel_red;
    logic [7:0]  texel_green;
    logic [7:0]  texel_blue;
    logic [4:0]  coord_s;
    logic [4:0]  coord_t;
    logic [7:0]  frac_s;
    logic [7:0]  frac_t;
  } lbs_in_t;

  typedef struct packed {
    logic [19:0] red_sum;
    logic [19:0] green_sum;
    logic [19:0] blue_sum;
  } lbs_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WEIGHT0,
    ST_WEIGHT1,
    ST_FETCH,
    ST_DRAIN,
    ST_SCALE,
    ST_DONE
  } lbs_state_t;

endpackage

@@ rtl/lightmap_bilinear_style_sampler.sv @@
// Bilinear RGB lightmap sampler with up to four light style layers.
// Requests enter on in_data when start is high and busy is low.
// A texel write request (action 0) is stored at that edge; busy stays low,
// so another request may follow in the next cycle.
// A sample request (action 1) raises busy until its result is out:
// the states ST_WEIGHT0 and ST_WEIGHT1 build the four bilinear weights and the row and layer offsets,
// then each style takes four reads of the single-port texel memory, a
// drain step to finish the weighted sum and a step to scale it by the style gain.
// All products go through one shared three-lane multiplier (one lane per
// color), which together with the memory port sets the cycle count.
// The result shows on out_data with out_valid high for exactly one cycle,
// in the first cycle with busy low again; a new request may be taken in that cycle.
// The receiver cannot hold results off.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Synchronous reset restores map size 2x2, one style and unity gains;
// texel memory contents are not cleared.
module lightmap_bilinear_style_sampler
  import lbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  lbs_in_t     in_data,
  output logic        out_valid,
  output lbs_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  logic [5:0]        map_width_r;
  logic [5:0]        map_height_r;
  logic [2:0]        style_count_r;
  logic [GAIN_W-1:0] gain_r [4];

  lbs_state_t state_r, state_nxt;
  lbs_in_t    item_r;

  logic [1:0]         tap_r;
  logic [STY_W-1:0]   style_r;
  logic               rd_valid_r;
  logic [1:0]         rd_tap_r;
  logic               rd_oob_r;
  logic [TEXEL_W-1:0] rdata_r;
  logic [WT_W-1:0]    wt_r [4];
  logic [CALC_W-1:0]  tw_r;
  logic [CALC_W-1:0]  layer_r;
  logic [CALC_W-1:0]  base_r;
  logic [SUM_W-1:0]   sum_r [LANES];
  logic [ACC_W-1:0]   acc_r [LANES];
  logic               out_valid_r;
  lbs_out_t           out_data_r;

  logic [TEXEL_W-1:0] mem [STORE_DEPTH];

  logic [SIDE_W-1:0]  w_c, h_c, s_c, t_c, s_lim, t_lim;
  logic [STY_W-1:0]   styles_c;
  logic [8:0]         a_c, b_c;
  logic [TEXEL_W-1:0] texel_c;
  logic [LANE_AW-1:0] mul_a [LANES];
  logic [LANE_BW-1:0] mul_b [LANES];
  logic [LANE_PW-1:0] mul_p [LANES];
  logic               rd_en;
  logic [CALC_W-1:0]  rd_addr;
  logic [CALC_W-1:0]  rd_offs;
  logic               wr_en;
  logic               accept;
  logic [ACC_W-1:0]   rnd [LANES];

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign wr_en     = accept && (in_data.action == ACT_WRITE) &&
                     (32'(in_data.texel_index) < STORE_DEPTH);

  // effective map size, clamped position and style count
  always_comb begin
    if (map_width_r < 6'd2) w_c = SIDE_W'(2);
    else if (32'(map_width_r) > MAX_SIDE) w_c = SIDE_W'(MAX_SIDE);
    else w_c = SIDE_W'(map_width_r);
    if (map_height_r < 6'd2) h_c = SIDE_W'(2);
    else if (32'(map_height_r) > MAX_SIDE) h_c = SIDE_W'(MAX_SIDE);
    else h_c = SIDE_W'(map_height_r);
    s_lim = w_c - SIDE_W'(2);
    t_lim = h_c - SIDE_W'(2);
    if (32'(item_r.coord_s) > 32'(s_lim)) s_c = s_lim;
    else s_c = SIDE_W'(item_r.coord_s);
    if (32'(item_r.coord_t) > 32'(t_lim)) t_c = t_lim;
    else t_c = SIDE_W'(item_r.coord_t);
    if (32'(style_count_r) > MAX_STYLES) styles_c = STY_W'(MAX_STYLES);
    else styles_c = STY_W'(style_count_r);
    a_c = 9'd256 - {1'b0, item_r.frac_s};
    b_c = 9'd256 - {1'b0, item_r.frac_t};
    texel_c = rd_oob_r ? '0 : rdata_r;
  end

  // shared three-lane multiplier
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      mul_p[i] = LANE_PW'(mul_a[i]) * LANE_PW'(mul_b[i]);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_data.action == ACT_SAMPLE) state_nxt = ST_WEIGHT0;
      end
      ST_WEIGHT0: state_nxt = ST_WEIGHT1;
      ST_WEIGHT1: begin
        if (styles_c == '0) state_nxt = ST_DONE;
        else state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        if (tap_r == 2'd3) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_SCALE;
      ST_SCALE: begin
        if (STY_W'(style_r + 1'b1) == styles_c) state_nxt = ST_DONE;
        else state_nxt = ST_FETCH;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs: lane operands and memory read
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      mul_a[i] = '0;
      mul_b[i] = '0;
    end
    rd_en = 1'b0;
    case (tap_r)
      2'd0:    rd_offs = '0;
      2'd1:    rd_offs = CALC_W'(1);
      2'd2:    rd_offs = CALC_W'(w_c) + CALC_W'(1);
      default: rd_offs = CALC_W'(w_c);
    endcase
    rd_addr = base_r + tw_r + CALC_W'(s_c) + rd_offs;
    if (rd_valid_r) begin
      // weighted texel of the previous read
      for (int i = 0; i < LANES; i++) begin
        mul_a[i] = LANE_AW'(texel_c[TEXEL_W-1-8*i -: 8]);
        mul_b[i] = LANE_BW'(wt_r[rd_tap_r]);
      end
    end
    case (state_r)
      ST_WEIGHT0: begin
        mul_a[0] = LANE_AW'(a_c);
        mul_b[0] = LANE_BW'(b_c);
        mul_a[1] = LANE_AW'(item_r.frac_s);
        mul_b[1] = LANE_BW'(b_c);
        mul_a[2] = LANE_AW'(item_r.frac_s);
        mul_b[2] = LANE_BW'(item_r.frac_t);
      end
      ST_WEIGHT1: begin
        mul_a[0] = LANE_AW'(a_c);
        mul_b[0] = LANE_BW'(item_r.frac_t);
        mul_a[1] = LANE_AW'(t_c);
        mul_b[1] = LANE_BW'(w_c);
        mul_a[2] = LANE_AW'(w_c);
        mul_b[2] = LANE_BW'(h_c);
      end
      ST_FETCH: rd_en = 1'b1;
      ST_SCALE: begin
        for (int i = 0; i < LANES; i++) begin
          mul_a[i] = LANE_AW'(sum_r[i]);
          mul_b[i] = LANE_BW'(gain_r[2'(style_r)]);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rnd[i] = acc_r[i] + ACC_W'(32768);
    end
  end

  // texel memory, single port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ADDR_W'(in_data.texel_index)] <=
        {in_data.texel_red, in_data.texel_green, in_data.texel_blue};
    end
    if (rd_en) begin
      rdata_r <= mem[ADDR_W'(rd_addr)];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r   <= 6'd2;
      map_height_r  <= 6'd2;
      style_count_r <= 3'd1;
      for (int i = 0; i < 4; i++) gain_r[i] <= GAIN_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAP_WIDTH:   map_width_r   <= cfg_data[5:0];
        CFG_MAP_HEIGHT:  map_height_r  <= cfg_data[5:0];
        CFG_STYLE_COUNT: style_count_r <= cfg_data[2:0];
        CFG_GAIN_ZERO:   gain_r[0]     <= cfg_data;
        CFG_GAIN_ONE:    gain_r[1]     <= cfg_data;
        CFG_GAIN_TWO:    gain_r[2]     <= cfg_data;
        CFG_GAIN_THREE:  gain_r[3]     <= cfg_data;
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_valid_r  <= rd_en;
      out_valid_r <= (state_r == ST_DONE);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rd_tap_r <= tap_r;
    rd_oob_r <= (32'(rd_addr) >= STORE_DEPTH);
    if (rd_valid_r) begin
      for (int i = 0; i < LANES; i++) begin
        sum_r[i] <= sum_r[i] + mul_p[i][SUM_W-1:0];
      end
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_r  <= in_data;
          tap_r   <= '0;
          style_r <= '0;
          base_r  <= '0;
          for (int i = 0; i < LANES; i++) begin
            sum_r[i] <= '0;
            acc_r[i] <= '0;
          end
        end
      end
      ST_WEIGHT0: begin
        wt_r[0] <= mul_p[0][WT_W-1:0];
        wt_r[1] <= mul_p[1][WT_W-1:0];
        wt_r[2] <= mul_p[2][WT_W-1:0];
      end
      ST_WEIGHT1: begin
        wt_r[3] <= mul_p[0][WT_W-1:0];
        tw_r    <= mul_p[1][CALC_W-1:0];
        layer_r <= mul_p[2][CALC_W-1:0];
      end
      ST_FETCH: tap_r <= tap_r + 2'd1;
      ST_SCALE: begin
        for (int i = 0; i < LANES; i++) begin
          acc_r[i] <= acc_r[i] + ACC_W'(mul_p[i]);
          sum_r[i] <= '0;
        end
        style_r <= style_r + 1'b1;
        base_r  <= base_r + layer_r;
      end
      ST_DONE: begin
        out_data_r.red_sum   <= rnd[0][35:16];
        out_data_r.green_sum <= rnd[1][35:16];
        out_data_r.blue_sum  <= rnd[2][35:16];
      end
      default: ;
    endcase
  end

endmodule
